FILE: design/hnco_pkg.sv
// Shared types, constants and table functions for the harmonic NCO.
// No dependencies; hnco_fill, hnco_interp and harmonic_nco import this package.
package hnco_pkg;

    // Widths of the phase, the samples and the sine memory
    localparam int PHASE_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int FRAC_W    = 16;
    localparam int NUM_H     = 3;
    localparam int QTR       = ENTRIES / 4;
    localparam int QTR_W     = $clog2(QTR);
    localparam int MAG_W     = SAMPLE_W - 1;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = DIFF_W + FRAC_W + 1;
    localparam int SUM_W     = PROD_W - FRAC_W;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 1'b0;

    // Stream payload widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = NUM_H * SAMPLE_W;

    // Fixed-point constants for building the table
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SMAX        = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

    // Saturation limits at the width of the interpolation sum
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(SMAX);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    typedef logic [QTR-1:0][MAG_W-1:0] t_qtab;

    typedef enum logic {
        FS_FILL,
        FS_RUN
    } t_fill_state;

    // Write request from the fill sequencer to the sine memories
    typedef struct packed {
        logic                       we;
        logic [IDX_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] data;
    } t_rom_wr;

    // Sine of x in [0, pi/2], argument and result both Q30
    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    // Magnitude of the table entry at quarter-wave position k (0 to QTR)
    function automatic logic [MAG_W-1:0] quarter_value(longint unsigned k);
        longint unsigned x;
        longint unsigned s;
        longint unsigned v;
        x = (HALF_PI_Q30 * (4 * k)) / ENTRIES;
        s = sin_q30(x);
        v = (s * SMAX + (64'd1 << 29)) >> 30;
        if (v > SMAX) begin
            v = SMAX;
        end
        return v[MAG_W-1:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab q;
        for (int k = 0; k < QTR; k++) begin
            q[k] = quarter_value(longint'(k));
        end
        return q;
    endfunction

    // Quarter-wave table and the peak value, both worked out at elaboration
    localparam t_qtab            QTAB  = build_qtab();
    localparam logic [MAG_W-1:0] QPEAK = quarter_value(longint'(QTR));

    // Full-period table entry, unfolded from the quarter-wave table
    function automatic logic signed [SAMPLE_W-1:0] rom_entry(logic [IDX_W-1:0] addr);
        logic [1:0]       quad;
        logic [QTR_W-1:0] r;
        logic [QTR_W:0]   k;
        logic [MAG_W-1:0] mag;
        logic [SAMPLE_W-1:0] ext;
        quad = addr[IDX_W-1 -: 2];
        r    = addr[QTR_W-1:0];
        k    = quad[0] ? ((QTR_W+1)'(QTR) - {1'b0, r}) : {1'b0, r};
        mag  = k[QTR_W] ? QPEAK : QTAB[k[QTR_W-1:0]];
        ext  = {1'b0, mag};
        return quad[1] ? $signed(-ext) : $signed(ext);
    endfunction

endpackage

FILE: design/hnco_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered data.
// No dependencies.
module hnco_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; the data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: design/hnco_fill.sv
// Fill sequencer: after reset it writes one sine period into the sine memories.
// Depends on hnco_pkg for the table function and the write request type.
module hnco_fill
    import hnco_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    output t_rom_wr o_wr,
    output logic    o_done
);

    t_fill_state      r_state;
    t_fill_state      n_state;
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] n_addr;

    // State and address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_FILL;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    // Sweep one entry per cycle, then stay in run for good
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        o_wr.we   = 1'b0;
        o_wr.addr = r_addr;
        o_wr.data = rom_entry(r_addr);
        o_done    = 1'b0;
        unique case (r_state)
            FS_FILL: begin
                o_wr.we = 1'b1;
                n_addr  = r_addr + IDX_W'(1);
                if (r_addr == IDX_W'(ENTRIES - 1)) begin
                    n_state = FS_RUN;
                end
            end
            FS_RUN: begin
                o_done = 1'b1;
            end
            default: begin
                n_state = FS_FILL;
            end
        endcase
    end

endmodule

FILE: design/hnco_interp.sv
// Linear interpolation between two sine entries, with saturation, for one harmonic.
// Depends on hnco_pkg for widths and saturation limits.
module hnco_interp
    import hnco_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en2,
    input  logic                       i_en3,
    input  logic [SAMPLE_W-1:0]        i_s0,
    input  logic [SAMPLE_W-1:0]        i_s1,
    input  logic [FRAC_W-1:0]          i_frac,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_s0;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] sat;
    logic signed [SAMPLE_W-1:0] r_sample;

    // Difference of the neighbouring entries times the fraction
    assign diff = $signed({i_s1[SAMPLE_W-1], i_s1}) - $signed({i_s0[SAMPLE_W-1], i_s0});

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_s0   <= $signed(i_s0);
            r_prod <= PROD_W'(diff) * PROD_W'($signed({1'b0, i_frac}));
        end
    end

    // Arithmetic shift floors the scaled product; then add and clamp
    assign sum = SUM_W'(r_s0) + r_prod[PROD_W-1:FRAC_W];

    always_comb begin
        priority if (sum > SAT_MAX) begin
            sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (sum < SAT_MIN) begin
            sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_sample <= sat;
        end
    end

    assign o_sample = r_sample;

endmodule

FILE: design/harmonic_nco.sv
// Harmonic NCO top level: phase accumulator, register port, sine memories and pipeline.
// Depends on hnco_pkg, hnco_ram, hnco_fill and hnco_interp.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata[0] restart
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: fundamental, 2nd, 3rd
//  apb       in/out     psel/penable/pwrite, pready   reg 0 phase step at 0x0
//
// One sample enters per cycle while the output is not stalled; each sample passes
// from transfer in to output through the sine memory read, the multiply, and the add and saturate.
// After reset the fill sequencer writes all 1024 sine memory entries; no input
// is taken during that time, register writes are.
// A stalled output fills the pipeline registers behind it before input stalls.
module harmonic_nco
    import hnco_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // [0] restart, rest zero
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // fundamental, second, third harmonic
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready
);

    t_rom_wr                 fill_wr;
    logic                    fill_done;
    logic [PHASE_W-1:0]      r_inc;
    logic [PHASE_W-1:0]      r_phase;
    logic [PHASE_W-1:0]      p;
    logic [PHASE_W-1:0]      h [NUM_H];
    logic [CFG_IDX_W-1:0]    cfg_idx;
    logic                    accept;
    logic                    en1;
    logic                    en2;
    logic                    en3;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic [FRAC_W-1:0]       r_frac [NUM_H];
    logic signed [SAMPLE_W-1:0] sample [NUM_H];

    // Register port: always ready, one register
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1 -: CFG_IDX_W];
    assign prdata  = (cfg_idx == REG_PHASE_INC) ? r_inc : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= '0;
        end else if (psel && penable && pwrite && pready && cfg_idx == REG_PHASE_INC) begin
            r_inc <= pwdata[PHASE_W-1:0];
        end
    end

    // Sine memory fill after reset
    hnco_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (fill_wr),
        .o_done  (fill_done)
    );

    // Pipeline enables: a stage loads when it is empty or its successor loads
    assign en3           = !r_v3 || m_axis_tready;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1 && fill_done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Phase of this sample and its double and triple, modulo a full turn
    assign p    = s_axis_tdata[0] ? '0 : r_phase;
    assign h[0] = p;
    assign h[1] = {p[PHASE_W-2:0], 1'b0};
    assign h[2] = p + {p[PHASE_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= p + r_inc;
            end
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // One sine memory and one interpolator per harmonic
    for (genvar j = 0; j < NUM_H; j++) begin : g_harm
        logic [IDX_W-1:0]    idx;
        logic [IDX_W-1:0]    nxt;
        logic [SAMPLE_W-1:0] s0;
        logic [SAMPLE_W-1:0] s1;

        assign idx = h[j][PHASE_W-1 -: IDX_W];
        assign nxt = idx + IDX_W'(1);

        always_ff @(posedge i_clk) begin
            if (en1) begin
                r_frac[j] <= h[j][PHASE_W-IDX_W-1 -: FRAC_W];
            end
        end

        hnco_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (ENTRIES)
        ) u_rom (
            .i_clk     (i_clk),
            .i_we      (fill_wr.we),
            .i_waddr   (fill_wr.addr),
            .i_wdata   (fill_wr.data),
            .i_re      (en1),
            .i_raddr_a (idx),
            .i_raddr_b (nxt),
            .o_rdata_a (s0),
            .o_rdata_b (s1)
        );

        hnco_interp u_interp (
            .i_clk    (i_clk),
            .i_en2    (en2),
            .i_en3    (en3),
            .i_s0     (s0),
            .i_s1     (s1),
            .i_frac   (r_frac[j]),
            .o_sample (sample[j])
        );

        assign m_axis_tdata[j*SAMPLE_W +: SAMPLE_W] = sample[j];
    end

    assign m_axis_tvalid = r_v3;

    // Checks on the fill interlock, the phase update and pipeline progress
    a_no_take_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_wr.we |-> !s_axis_tready)
        else $error("input taken while the sine memories are being filled");

    a_idle_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fill_done |-> !r_v1 && !r_v2 && !r_v3)
        else $error("pipeline holds a sample during the fill");

    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tdata[0] |=> r_phase == $past(r_inc))
        else $error("phase after restart is not the increment");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_v3 |=> r_v3)
        else $error("sample stuck ahead of an empty output register");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the harmonic NCO: stream and register port stimulus,
// with a scoreboard that predicts the three sine samples of every sample tick.
// Depends on hnco_pkg and the harmonic_nco design files only.
`timescale 1ns / 1ps

module tb_top;
    import hnco_pkg::*;

    localparam int          TAB_SIZE      = 1024;
    localparam int          TAB_BITS      = 10;
    localparam int          ACC_W         = 32;
    localparam longint      PEAK          = 32767;
    localparam longint unsigned ONE_Q30   = 64'd1 << 30;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          HOLD_OFF      = 80;

    // Byte addresses on the register port: the step register and an unmapped word
    localparam logic [CFG_ADDR_W-1:0] INC_ADDR   = {REG_PHASE_INC, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {~REG_PHASE_INC, 2'b00};

    // Three samples of one tick, as they appear on the output
    typedef struct {
        logic signed [SAMPLE_W-1:0] fundamental;
        logic signed [SAMPLE_W-1:0] harm2;
        logic signed [SAMPLE_W-1:0] harm3;
    } t_trio;

    // Scoreboard: keeps its own phase, step and sine table, and the samples still owed
    class nco_tracker;
        bit [ACC_W-1:0] step;
        bit [ACC_W-1:0] phase;
        int             sine_tab[TAB_SIZE];
        t_trio          awaited[$];
        int             errors;
        int             ticks;
        int             restarts;
        int             settings;

        function new();
            for (int i = 0; i < TAB_SIZE; i++) begin
                sine_tab[i] = table_entry(i);
            end
        endfunction

        // Odd polynomial for the sine over a quarter turn, all in Q30
        function longint unsigned q30_sine(longint unsigned x);
            longint unsigned xx;
            longint unsigned acc;
            xx  = (x * x) >> 30;
            acc = ONE_Q30 - xx / 110;
            acc = ONE_Q30 - ((xx * acc) >> 30) / 72;
            acc = ONE_Q30 - ((xx * acc) >> 30) / 42;
            acc = ONE_Q30 - ((xx * acc) >> 30) / 20;
            acc = ONE_Q30 - ((xx * acc) >> 30) / 6;
            return (x * acc) >> 30;
        endfunction

        // One entry of the full-period table, folded through the quadrants
        function int table_entry(int i);
            longint unsigned quarter4;
            longint unsigned quad;
            longint unsigned rem;
            longint unsigned m;
            longint unsigned mag;
            quarter4 = 4 * longint'(i);
            quad     = quarter4 / TAB_SIZE;
            rem      = quarter4 % TAB_SIZE;
            m        = quad[0] ? (TAB_SIZE - rem) : rem;
            mag      = (q30_sine((QUARTER_TURN_Q30 * m) / TAB_SIZE) * PEAK
                        + (64'd1 << 29)) >> 30;
            if (mag > PEAK) begin
                mag = PEAK;
            end
            return quad[1] ? -int'(mag) : int'(mag);
        endfunction

        // Linear interpolation between neighbouring entries; the next index wraps
        function logic signed [SAMPLE_W-1:0] interp(bit [ACC_W-1:0] ph);
            bit [TAB_BITS-1:0] lo;
            bit [TAB_BITS-1:0] hi;
            bit [15:0]         f;
            longint            s0;
            longint            r;
            lo = ph[ACC_W-1 -: TAB_BITS];
            hi = lo + 1'b1;
            f  = ph[ACC_W-TAB_BITS-1 -: 16];
            s0 = sine_tab[lo];
            r  = s0 + (((longint'(sine_tab[hi]) - s0) * longint'(f)) >>> 16);
            if (r > PEAK) begin
                r = PEAK;
            end
            if (r < -PEAK - 1) begin
                r = -PEAK - 1;
            end
            return r[SAMPLE_W-1:0];
        endfunction

        // An accepted sample tick: restart first, then three lookups, then advance
        function void note_tick(bit restart);
            t_trio e;
            if (restart) begin
                phase = '0;
                restarts++;
            end
            e.fundamental = interp(phase);
            e.harm2       = interp(phase * 2);
            e.harm3       = interp(phase * 3);
            awaited.push_back(e);
            phase = phase + step;
            ticks++;
        endfunction

        // The register is selected by its word address; the byte offset is ignored
        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr[CFG_ADDR_W-1:2] == REG_PHASE_INC) begin
                step = data;
                settings++;
            end
        endfunction

        function void compare(string name, logic signed [SAMPLE_W-1:0] want,
                              logic signed [SAMPLE_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_samples(logic [OUT_DATA_W-1:0] data);
            t_trio e;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, got %h",
                         $time, data);
                errors++;
            end else begin
                e = awaited.pop_front();
                compare("fundamental", e.fundamental, data[SAMPLE_W-1:0]);
                compare("second harmonic", e.harm2, data[2*SAMPLE_W-1:SAMPLE_W]);
                compare("third harmonic", e.harm3, data[3*SAMPLE_W-1:2*SAMPLE_W]);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [0] restart, rest zero
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // fundamental, second, third harmonic
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    nco_tracker tracker;
    bit         calm;
    int         hold_ticks;
    int         cycle_count;

    harmonic_nco u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Every transfer on either stream and every register write is mirrored into the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            tracker.note_tick(s_axis_tdata[0]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_samples(m_axis_tdata);
        end
        if (i_rst_n && psel && penable && pwrite && pready) begin
            tracker.write_reg(paddr, pwdata);
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_ticks > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_ticks) @(posedge i_clk);
                hold_ticks = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one sample tick, after an occasional idle burst, and wait for its transfer.
    task automatic send_tick(input bit restart);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(restart);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering input and wait until every owed result has come out.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_ticks(input int count);
        for (int n = 0; n < count; n++) begin
            send_tick($urandom_range(0, 11) == 0);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom() >> $urandom_range(8, 31);
            2:       return ~($urandom() >> $urandom_range(8, 31));
            default: return {4'($urandom_range(0, 15)), 28'h0};
        endcase
    endfunction

    initial begin
        tracker       = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        calm          = 1'b0;
        hold_ticks    = 0;
        cycle_count   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero step from reset: the phase must stay put.
        send_tick(1'b1);
        send_tick(1'b0);
        settle();

        // Quarter-turn step lands on the zero crossings and both peaks.
        apb_write(INC_ADDR, 32'h4000_0000);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        settle();

        // A write to an unmapped address must leave the step untouched.
        apb_write(SPARE_ADDR, 32'h1234_5678);
        repeat (3) send_tick(1'b0);
        settle();

        // All-ones step walks backwards from zero across the table wrap.
        apb_write(INC_ADDR, 32'hFFFF_FFFF);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        settle();

        // Smallest non-zero step.
        apb_write(INC_ADDR, 32'h0000_0001);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        settle();

        // Third of a turn: the harmonics wrap past a full turn.
        apb_write(INC_ADDR, 32'h5555_5555);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        settle();

        apb_write(INC_ADDR, 32'h0000_0000);
        repeat (2) send_tick(1'b0);
        settle();

        // Random steps; one phase has the output held off so the pipeline backs up.
        for (int k = 0; k < 7; k++) begin
            apb_write(INC_ADDR, pick_step());
            if (k == 3) begin
                hold_ticks = HOLD_OFF;
            end
            run_ticks(55);
            settle();
        end

        // Closing stretch at full rate with no idling on either side.
        calm = 1'b1;
        apb_write(INC_ADDR, pick_step());
        run_ticks(45);
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d sample ticks (%0d restarts) over %0d phase step settings.",
                 tracker.ticks, tracker.restarts, tracker.settings);
        $display("Steps covered zero, one, all ones and random values, with stalls both sides.");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/hnco_pkg.sv
design/hnco_ram.sv
design/hnco_fill.sv
design/hnco_interp.sv
design/harmonic_nco.sv
sim/tb_top.sv
